// ===== hw/rtl/rss_pkg.sv =====
// Shared types, constants and helpers for the record sort-by-name block.
// No dependencies; compiled before every other file.
package rss_pkg;

  localparam int KEY_BYTES_MAX = 32;
  localparam int KEY_BITS      = 8 * KEY_BYTES_MAX;
  localparam int RANK_W        = 5;

  typedef struct packed {
    logic signed [31:0] student_id;
    logic signed [31:0] study_year;
    logic [63:0]        key_word_0;
    logic [63:0]        key_word_1;
    logic [63:0]        key_word_2;
    logic [63:0]        key_word_3;
    logic               final_record;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_id;
    logic signed [31:0] out_year;
    logic [63:0]        out_key_0;
    logic [63:0]        out_key_1;
    logic [63:0]        out_key_2;
    logic [63:0]        out_key_3;
    logic [RANK_W-1:0]  sorted_rank;
    logic               run_end;
    logic               dropped_flag;
  } out_item_t;

  // Stored record; key byte 0 sits in the most significant byte.
  typedef struct packed {
    logic signed [31:0]  id;
    logic signed [31:0]  year;
    logic [KEY_BITS-1:0] key;
  } rec_t;

  // Controller to datapath commands, at most one per cycle.
  typedef struct packed {
    logic load;
    logic rd_i;
    logic cap_i;
    logic scan;
    logic swap_a;
    logic swap_b;
    logic emit_rd;
    logic emit_cap;
    logic clear;
  } rss_cmd_t;

  typedef struct packed {
    logic pass_more;
    logic scan_more;
    logic emit_done;
  } rss_status_t;

  // Clear every byte after the first zero byte, so a plain unsigned compare
  // of two cleaned keys orders them as a string compare does.
  function automatic logic [KEY_BITS-1:0] key_clean(input logic [KEY_BITS-1:0] key);
    logic [KEY_BYTES_MAX-1:0] nz;
    logic [KEY_BYTES_MAX-1:0] lower;
    logic [KEY_BITS-1:0]      res;
    logic                     keep;
    for (int b = 0; b < KEY_BYTES_MAX; b++) begin
      nz[b] = |key[KEY_BITS-1-8*b -: 8];
    end
    for (int b = 0; b < KEY_BYTES_MAX; b++) begin
      lower = ~({KEY_BYTES_MAX{1'b1}} << b);
      keep  = &(nz | ~lower);
      res[KEY_BITS-1-8*b -: 8] = keep ? key[KEY_BITS-1-8*b -: 8] : 8'h00;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rss_chan_if.sv =====
// Valid/ready channel carrying one item per handshake.
// Payload type is set at instantiation; no package dependency.
interface rss_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/rss_ctrl.sv =====
// Sequencer for load, selection-sort passes and emission.
// Uses rss_pkg command and status types; drives the rss_dpath datapath.
module rss_ctrl
  import rss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_final,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  rss_status_t status,
  output rss_cmd_t    cmd
);

  localparam logic [2:0] ST_LOAD     = 3'd0;
  localparam logic [2:0] ST_CHECK    = 3'd1;
  localparam logic [2:0] ST_CAP_I    = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_SWAP_A   = 3'd4;
  localparam logic [2:0] ST_SWAP_B   = 3'd5;
  localparam logic [2:0] ST_EMIT_CAP = 3'd6;
  localparam logic [2:0] ST_EMIT_OUT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_EMIT_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_final) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (status.pass_more) begin
          cmd.rd_i  = 1'b1;
          state_nxt = ST_CAP_I;
        end else begin
          cmd.emit_rd = 1'b1;
          state_nxt   = ST_EMIT_CAP;
        end
      end
      ST_CAP_I: begin
        cmd.cap_i = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        // last compare of the pass when no further read is pending
        if (!status.scan_more) begin
          state_nxt = ST_SWAP_A;
        end
      end
      ST_SWAP_A: begin
        cmd.swap_a = 1'b1;
        state_nxt  = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        cmd.swap_b = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_EMIT_CAP: begin
        cmd.emit_cap = 1'b1;
        state_nxt    = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_ready) begin
          if (status.emit_done) begin
            cmd.clear = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            cmd.emit_rd = 1'b1;
            state_nxt   = ST_EMIT_CAP;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rss_dpath.sv =====
// Record memory, pass/scan/emit counters, key compare and output register.
// Uses rss_pkg types and key_clean; commanded by rss_ctrl.
module rss_dpath
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS = 32,
  parameter int KEY_BYTES   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rss_cmd_t    cmd,
  input  in_item_t    in_item,
  output rss_status_t status,
  output out_item_t   out_item
);

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [KEY_BITS-1:0] KeyMask =
    {KEY_BITS{1'b1}} << (8 * (KEY_BYTES_MAX - KEY_BYTES));

  rec_t rec_mem_r [MAX_RECORDS];

  logic [CW-1:0]       count_r;
  logic                ovf_r;
  logic [CW-1:0]       i_r;
  logic [CW-1:0]       j_r;
  logic [CW-1:0]       k_r;
  logic [AW-1:0]       best_idx_r;
  logic [AW-1:0]       rd_idx_r;
  rec_t                rd_data_r;
  rec_t                best_r;
  rec_t                rec_i_r;
  logic [KEY_BITS-1:0] best_clean_r;
  out_item_t           out_r;

  logic                has_room;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  rec_t                wr_data;
  rec_t                load_rec;
  logic [KEY_BITS-1:0] rd_clean;
  logic                take_new;

  assign has_room = (count_r < CW'(MAX_RECORDS));

  assign status.pass_more = ((i_r + CW'(1)) < count_r);
  assign status.scan_more = (j_r < count_r);
  assign status.emit_done = (k_r == count_r);

  assign load_rec.id   = in_item.student_id;
  assign load_rec.year = in_item.study_year;
  assign load_rec.key  = {in_item.key_word_0, in_item.key_word_1,
                          in_item.key_word_2, in_item.key_word_3} & KeyMask;

  assign rd_clean = key_clean(rd_data_r.key);
  assign take_new = (best_clean_r > rd_clean);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i_r[AW-1:0];
    if (cmd.rd_i) begin
      rd_en = 1'b1;
    end else if (cmd.cap_i || (cmd.scan && status.scan_more)) begin
      rd_en   = 1'b1;
      rd_addr = j_r[AW-1:0];
    end else if (cmd.emit_rd) begin
      rd_en   = 1'b1;
      rd_addr = k_r[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = load_rec;
    if (cmd.load && has_room) begin
      wr_en = 1'b1;
    end else if (cmd.swap_a) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = rec_i_r;
    end else if (cmd.swap_b) begin
      wr_en   = 1'b1;
      wr_addr = i_r[AW-1:0];
      wr_data = best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= rec_mem_r[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.load) begin
        if (has_room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.rd_i) begin
        j_r <= i_r + CW'(1);
      end
      if (cmd.cap_i || (cmd.scan && status.scan_more)) begin
        j_r <= j_r + CW'(1);
      end
      if (cmd.swap_b) begin
        i_r <= i_r + CW'(1);
      end
      if (cmd.emit_cap) begin
        k_r <= k_r + CW'(1);
      end
      if (cmd.clear) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        i_r     <= '0;
        k_r     <= '0;
      end
    end
  end

  // Best-so-far tracking; strict compare keeps the first smallest key.
  always_ff @(posedge clk) begin
    if (cmd.cap_i) begin
      best_r       <= rd_data_r;
      rec_i_r      <= rd_data_r;
      best_clean_r <= rd_clean;
      best_idx_r   <= rd_idx_r;
    end else if (cmd.scan && take_new) begin
      best_r       <= rd_data_r;
      best_clean_r <= rd_clean;
      best_idx_r   <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_cap) begin
      out_r.out_id       <= rd_data_r.id;
      out_r.out_year     <= rd_data_r.year;
      out_r.out_key_0    <= rd_data_r.key[KEY_BITS-1 -: 64];
      out_r.out_key_1    <= rd_data_r.key[KEY_BITS-65 -: 64];
      out_r.out_key_2    <= rd_data_r.key[KEY_BITS-129 -: 64];
      out_r.out_key_3    <= rd_data_r.key[KEY_BITS-193 -: 64];
      out_r.sorted_rank  <= RANK_W'(k_r);
      out_r.run_end      <= ((k_r + CW'(1)) == count_r);
      out_r.dropped_flag <= ovf_r;
    end
  end

  assign out_item = out_r;

endmodule

// ===== hw/rtl/record_selection_sort_by_name.sv =====
// Batch record sorter by name key: loads one record per cycle, then sorts
// in place with selection sort over a single-port record memory.
// Each sort pass steps through CHECK, CAP_I, SCAN, SWAP_A and SWAP_B, with one
// memory read per compare; each record then leaves through EMIT_CAP and EMIT_OUT,
// waiting on output ready. No new record is taken until the whole batch has left.
// Reset (synchronous, rst_n low) empties the batch; memory is not cleared.
module record_selection_sort_by_name
  import rss_pkg::*;
#(
  parameter int MAX_RECORDS = 32,
  parameter int KEY_BYTES   = 32
) (
  input logic          clk,
  input logic          rst_n,
  rss_chan_if.sink     in_chan,
  rss_chan_if.source   out_chan
);

  rss_cmd_t    cmd;
  rss_status_t status;
  in_item_t    in_item;
  out_item_t   out_item;
  logic        in_ready;
  logic        out_valid;

  assign in_item          = in_chan.payload;
  assign in_chan.ready    = in_ready;
  assign out_chan.valid   = out_valid;
  assign out_chan.payload = out_item;

  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_final  (in_item.final_record),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rss_dpath #(
    .MAX_RECORDS (MAX_RECORDS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .status   (status),
    .out_item (out_item)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("loading and emitting at the same time");

  a_final_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_ready && in_item.final_record) |=> !in_ready)
    else $error("still loading after the final item");

  a_end_resumes_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_chan.ready && out_item.run_end) |=> in_ready)
    else $error("not back to loading after the last result");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for record_selection_sort_by_name: loads record batches, predicts the
// selection-sorted output order and checks every emitted item field by field.
// Depends on rss_pkg and rss_chan_if from the RTL.
module tb;
  import rss_pkg::*;

  localparam int MAX_RECORDS = 32;
  localparam int NAME_BYTES  = 32;
  localparam logic [7:0] NAME_CHARS [8] = '{8'h01, 8'h41, 8'h42, 8'h61,
                                            8'h62, 8'h7A, 8'h80, 8'hFF};

  logic clk;
  logic rst_n;

  rss_chan_if #(.payload_t(in_item_t))  in_if ();
  rss_chan_if #(.payload_t(out_item_t)) out_if ();

  record_selection_sort_by_name #(
    .MAX_RECORDS(MAX_RECORDS),
    .KEY_BYTES  (NAME_BYTES)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // Shadow of the record store and the batch status
  rec_t      batch_recs [MAX_RECORDS];
  int        batch_count;
  bit        batch_dropped;
  out_item_t sorted_expect [$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int records_sent;
  int batches_closed;
  int overflow_batches;
  int items_checked;
  logic [KEY_BITS-1:0] last_name;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // strcmp order over the name bytes
  function automatic int name_order(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b);
    logic [7:0] ca;
    logic [7:0] cb;
    for (int i = 0; i < NAME_BYTES; i++) begin
      ca = a[KEY_BITS-1-8*i -: 8];
      cb = b[KEY_BITS-1-8*i -: 8];
      if (ca != cb) return (ca < cb) ? -1 : 1;
      if (ca == 8'h00) return 0;
    end
    return 0;
  endfunction

  task automatic take_record(input in_item_t it);
    logic [KEY_BITS-1:0] name;
    rec_t                tmp;
    int                  best;
    out_item_t           res;
    if (batch_count < MAX_RECORDS) begin
      name = {it.key_word_0, it.key_word_1, it.key_word_2, it.key_word_3};
      for (int b = NAME_BYTES; b < KEY_BYTES_MAX; b++) name[KEY_BITS-1-8*b -: 8] = 8'h00;
      batch_recs[batch_count] = '{id: it.student_id, year: it.study_year, key: name};
      batch_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!it.final_record) return;
    for (int i = 0; i + 1 < batch_count; i++) begin
      best = i;
      for (int j = i; j < batch_count; j++)
        if (name_order(batch_recs[best].key, batch_recs[j].key) > 0) best = j;
      tmp              = batch_recs[i];
      batch_recs[i]    = batch_recs[best];
      batch_recs[best] = tmp;
    end
    for (int k = 0; k < batch_count; k++) begin
      res.out_id       = batch_recs[k].id;
      res.out_year     = batch_recs[k].year;
      res.out_key_0    = batch_recs[k].key[255:192];
      res.out_key_1    = batch_recs[k].key[191:128];
      res.out_key_2    = batch_recs[k].key[127:64];
      res.out_key_3    = batch_recs[k].key[63:0];
      res.sorted_rank  = k[RANK_W-1:0];
      res.run_end      = (k + 1 == batch_count);
      res.dropped_flag = batch_dropped;
      sorted_expect.push_back(res);
    end
    batches_closed++;
    if (batch_dropped) overflow_batches++;
    batch_count   = 0;
    batch_dropped = 1'b0;
  endtask

  function automatic in_item_t make_record(input logic [31:0] id, input logic [31:0] year,
                                           input logic [KEY_BITS-1:0] name, input logic fin);
    in_item_t it;
    it.student_id   = id;
    it.study_year   = year;
    it.key_word_0   = name[255:192];
    it.key_word_1   = name[191:128];
    it.key_word_2   = name[127:64];
    it.key_word_3   = name[63:0];
    it.final_record = fin;
    return it;
  endfunction

  function automatic logic [KEY_BITS-1:0] name_key(input string s);
    logic [KEY_BITS-1:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < KEY_BYTES_MAX; i++) k[KEY_BITS-1-8*i -: 8] = s[i];
    return k;
  endfunction

  function automatic logic [KEY_BITS-1:0] random_name(input logic [KEY_BITS-1:0] prev);
    logic [KEY_BITS-1:0] k;
    int mode;
    int len;
    int pos;
    mode = $urandom_range(9);
    if (mode < 2) begin
      for (int w = 0; w < 8; w++) k[32*w +: 32] = $urandom;
    end else if (mode < 4) begin
      k   = prev;
      pos = $urandom_range(KEY_BYTES_MAX - 1);
      k[KEY_BITS-1-8*pos -: 8] = NAME_CHARS[$urandom_range(7)];
    end else if (mode == 4) begin
      k = prev;
    end else begin
      k   = '0;
      len = ($urandom_range(19) == 0) ? $urandom_range(KEY_BYTES_MAX) : $urandom_range(6);
      for (int i = 0; i < len; i++) k[KEY_BITS-1-8*i -: 8] = NAME_CHARS[$urandom_range(7)];
      // leave junk behind the terminator now and then
      if (len < KEY_BYTES_MAX - 1 && $urandom_range(3) == 0)
        for (int i = len + 1; i < KEY_BYTES_MAX; i++)
          k[KEY_BITS-1-8*i -: 8] = 8'($urandom_range(255));
    end
    return k;
  endfunction

  task automatic send_record(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    records_sent++;
    take_record(it);
  endtask

  // Hold the input until every expected item is out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sorted_expect.size() > 0) @(posedge clk);
  endtask

  task automatic send_batch(input int size);
    logic [KEY_BITS-1:0] name;
    for (int k = 0; k < size; k++) begin
      name      = random_name(last_name);
      last_name = name;
      send_record(make_record($urandom, $urandom, name, k == size - 1));
    end
  endtask

  task automatic test_single_records();
    send_record(make_record(32'h8000_0000, 32'h7FFF_FFFF, {KEY_BITS{1'b1}}, 1'b1));
    send_record(make_record(32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b1));
  endtask

  task automatic test_name_order();
    logic [KEY_BITS-1:0] k;
    send_record(make_record(1, 2000, name_key("b"), 1'b0));
    send_record(make_record(2, 2001, name_key("a"), 1'b0));
    k = '0; k[255:248] = 8'hFF;
    send_record(make_record(3, 2002, k, 1'b0));
    k = '0; k[255:248] = 8'h01;
    send_record(make_record(4, 2003, k, 1'b0));
    send_record(make_record(5, 2004, name_key("ab"), 1'b0));
    // same name as "a" once the terminator is honored
    k = name_key("a"); k[239:224] = 16'h7A7A;
    send_record(make_record(6, 2005, k, 1'b0));
    send_record(make_record(7, 2006, '0, 1'b0));
    send_record(make_record(8, 2007, name_key("a"), 1'b0));
    k = {KEY_BYTES_MAX{8'h7A}};
    send_record(make_record(9, 2008, k, 1'b0));
    k[7:0] = 8'h79;
    send_record(make_record(10, 2009, k, 1'b0));
    k = name_key("_a"); k[255:248] = 8'h80;
    send_record(make_record(11, 2010, k, 1'b1));
    // full-length names, equal and differing only in the last byte
    k = {KEY_BYTES_MAX{8'hC3}};
    send_record(make_record(20, -1, k, 1'b0));
    send_record(make_record(21, 0, k, 1'b0));
    k[7:0] = 8'h00;
    send_record(make_record(22, 1, k, 1'b1));
  endtask

  task automatic test_overflow();
    wait_drained();
    send_batch(MAX_RECORDS + 4);
    wait_drained();
    // fill exactly to capacity, then overflow with a dropped closing record
    send_batch(MAX_RECORDS);
    send_batch(MAX_RECORDS + 1);
  endtask

  task automatic test_random_batches(input int n_items);
    int start;
    int pick;
    int size;
    start = records_sent;
    while (records_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 65)      size = $urandom_range(1, 6);
      else if (pick < 88) size = $urandom_range(7, 16);
      else if (pick < 96) size = $urandom_range(MAX_RECORDS - 1, MAX_RECORDS);
      else                size = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
      send_batch(size);
      if ($urandom_range(9) < 3) wait_drained();
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (sorted_expect.size() == 0) begin
        $error("sorted item with id %0d arrived with none expected", got.out_id);
        fail_count++;
      end else begin
        want = sorted_expect.pop_front();
        check_field("out_id", 64'(want.out_id), 64'(got.out_id));
        check_field("out_year", 64'(want.out_year), 64'(got.out_year));
        check_field("out_key_0", want.out_key_0, got.out_key_0);
        check_field("out_key_1", want.out_key_1, got.out_key_1);
        check_field("out_key_2", want.out_key_2, got.out_key_2);
        check_field("out_key_3", want.out_key_3, got.out_key_3);
        check_field("sorted_rank", 64'(want.sorted_rank), 64'(got.sorted_rank));
        check_field("run_end", 64'(want.run_end), 64'(got.run_end));
        check_field("dropped_flag", 64'(want.dropped_flag), 64'(got.dropped_flag));
        items_checked++;
      end
    end
  end

  initial begin
    int waited;
    fail_count       = 0;
    records_sent     = 0;
    batches_closed   = 0;
    overflow_batches = 0;
    items_checked    = 0;
    batch_count      = 0;
    batch_dropped    = 1'b0;
    last_name        = '0;
    send_idle_pct    = 8;
    recv_stall_pct   = 75;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_records();
    test_name_order();
    test_overflow();
    test_random_batches(120);
    send_idle_pct  = 75;
    recv_stall_pct = 8;
    test_random_batches(120);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_batches(120);

    in_if.valid <= 1'b0;
    waited = 0;
    while (sorted_expect.size() > 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sorted_expect.size() > 0) begin
      $error("%0d sorted items never arrived", sorted_expect.size());
      fail_count++;
    end

    $display("Loaded %0d records in %0d batches, %0d of them over capacity;",
             records_sent, batches_closed, overflow_batches);
    $display("checked %0d sorted items under three sender/receiver stall mixes.",
             items_checked);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rss_pkg.sv
hw/rtl/rss_chan_if.sv
hw/rtl/rss_ctrl.sv
hw/rtl/rss_dpath.sv
hw/rtl/record_selection_sort_by_name.sv
test/tb.sv
